@@ src/sid_pkg.sv @@
// Package: widths, limits and sequencer states for the signed integer divider.
`timescale 1ns / 1ps
`default_nettype none
package sid_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIX
  } sid_state_t;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } sid_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } sid_rsp_t;

endpackage
`default_nettype wire

@@ src/signed_integer_divider.sv @@
// Top level: signed integer divider with magnitude fix-up and output register.
// One transaction at a time: in_ready is low from acceptance until the result is loaded
// into the output register, while the shift-subtract unit works through its DATA_WIDTH
// quotient bits and while the sign fix-up waits for the output register.
// A finished result waits in the output register; the next input is taken meanwhile.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module signed_integer_divider
  import sid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-1:0] in_dividend,
  input  wire logic [DATA_WIDTH-1:0] in_divisor,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      out_quotient,
  output logic                       out_overflow,
  output logic                       out_div_by_zero
);

  sid_state_t state_r, state_nxt;
  sid_req_t   req;
  sid_rsp_t   rsp;

  logic  in_acc;
  logic  out_load;
  logic  neg_r, dbz_r;
  logic  out_valid_r;
  word_t quo_r, quo_nxt;
  logic  ovf_r, ovf_nxt;
  logic  dbz_out_r;

  assign in_acc = in_valid & in_ready;

  always_comb begin
    req.start = in_acc;
    req.num   = in_dividend[DATA_WIDTH-1] ? (~in_dividend + 1'b1) : in_dividend;
    req.den   = in_divisor[DATA_WIDTH-1]  ? (~in_divisor + 1'b1)  : in_divisor;
  end

  sid_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CALC;
      ST_CALC: if (rsp.done) state_nxt = ST_FIX;
      ST_FIX:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_CALC: ;
      ST_FIX:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    ovf_nxt = 1'b0;
    priority if (dbz_r) begin
      quo_nxt = '0;
    end else if (rsp.quo == INT_MIN && !neg_r) begin
      quo_nxt = INT_MAX;
      ovf_nxt = 1'b1;
    end else if (neg_r) begin
      quo_nxt = ~rsp.quo + 1'b1;
    end else begin
      quo_nxt = rsp.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r <= in_dividend[DATA_WIDTH-1] ^ in_divisor[DATA_WIDTH-1];
      dbz_r <= (in_divisor == '0);
    end
    if (out_load) begin
      quo_r     <= quo_nxt;
      ovf_r     <= ovf_nxt;
      dbz_out_r <= dbz_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quotient    = quo_r;
  assign out_overflow    = ovf_r;
  assign out_div_by_zero = dbz_out_r;

endmodule
`default_nettype wire

@@ src/sid_core.sv @@
// Iterative restoring divider of unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sid_core
  import sid_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sid_req_t req,
  output sid_rsp_t      rsp
);

  word_t            num_r, num_nxt;
  word_t            den_r, den_nxt;
  word_t            rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  logic [DATA_WIDTH:0] rem_sh;
  logic [DATA_WIDTH:0] diff;
  logic                fits;

  assign rem_sh = {rem_r, num_r[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = ~diff[DATA_WIDTH];

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt = req.num;
      den_nxt = req.den;
      rem_nxt = '0;
      cnt_nxt = CNT_LAST;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      num_nxt = {num_r[DATA_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule
`default_nettype wire

@@ src/sid_checker.sv @@
// Port-level checker for the signed integer divider, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sid_checker
  import sid_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [DATA_WIDTH-1:0] in_dividend,
  input wire logic [DATA_WIDTH-1:0] in_divisor,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] out_quotient,
  input wire logic                  out_overflow,
  input wire logic                  out_div_by_zero
);

  a_busy_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##1 (!in_ready)[*(DATA_WIDTH + 2)])
    else $error("in_ready high while a transaction is being divided");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_dividend) && $stable(in_divisor)))
    else $error("waiting input transaction changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_quotient)))
    else $error("stalled result changed");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> (out_quotient == '0 && !out_overflow))
    else $error("divide by zero result not clean");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_quotient == INT_MAX && !out_div_by_zero))
    else $error("overflow without saturation");

endmodule

bind signed_integer_divider sid_checker u_sid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_dividend     (in_dividend),
  .in_divisor      (in_divisor),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_quotient    (out_quotient),
  .out_overflow    (out_overflow),
  .out_div_by_zero (out_div_by_zero)
);
`default_nettype wire
